// File: hdl/box_downscale_rgb565_rotate_macros.svh
// assertion macros for the box downscaler
// used by box_downscale_rgb565_rotate.sv
`ifndef BOX_DOWNSCALE_RGB565_ROTATE_MACROS_SVH
`define BOX_DOWNSCALE_RGB565_ROTATE_MACROS_SVH

// same-cycle implication
`define BDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/bds_pkg.sv
// shared types and constants for the box downscaler
// no dependencies
`default_nettype none
package bds_pkg;
   localparam int SRC_W = 13;
   localparam int DST_W = 10;
   localparam int CHAN_W = 8;
   localparam int SUM_W = 32;
   localparam int ADDR_OUT_W = 18;
   localparam int CSR_IDX_W = 2;

   // largest usable source size; channel sums of a full box fit in SUM_W
   localparam int MAX_SOURCE_DIM = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 2'd3;

   typedef logic [SUM_W-1:0] word_type;
   typedef word_type [2:0] trio_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage
`default_nettype wire

// File: hdl/box_downscale_rgb565_rotate.sv
// Box downscaler: RGB888 in, RGB565 out with 90-degree rotated address.
// A pixel that closes no box is taken in ST_IDLE, one that closes a box in a non-final
// row also passes ST_ACC; a final-row box goes via ST_ACC, ST_DIV and ST_PUT, which waits
// for a free output (32-step shared divider). One pixel at a time.
// Synchronous reset restores default sizes; ratios are recomputed in ST_CFG and ST_AREA
// before the first transfer after reset is released and after a register write.
`default_nettype none
module box_downscale_rgb565_rotate #(
   parameter int MAX_TARGET_WIDTH = 512,
   parameter int MAX_TARGET_HEIGHT = 512
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [bds_pkg::CHAN_W-1:0] req_red_in,
   input  wire logic [bds_pkg::CHAN_W-1:0] req_green_in,
   input  wire logic [bds_pkg::CHAN_W-1:0] req_blue_in,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [bds_pkg::ADDR_OUT_W-1:0] rsp_pixel_address,
   output logic [15:0] rsp_pixel_565,
   output logic rsp_frame_done,
   input  wire logic csr_write_enable,
   input  wire logic [bds_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bds_pkg::SRC_W-1:0] csr_write_data
);
   import bds_pkg::*;
   `include "box_downscale_rgb565_rotate_macros.svh"

   localparam int AW = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CFG = 3'd1;
   localparam logic [2:0] ST_AREA = 3'd2;
   localparam logic [2:0] ST_ACC = 3'd3;
   localparam logic [2:0] ST_DIV = 3'd4;
   localparam logic [2:0] ST_PUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [SRC_W-1:0] sw_ff, sh_ff;
   logic [DST_W-1:0] tw_ff, th_ff;
   logic dirty_ff, dirty_in;
   logic [SRC_W-1:0] wr_ff, hr_ff, wr_in, hr_in;
   logic [2*SRC_W-1:0] area_ff, area_in;
   logic ok_ff, ok_in;

   trio_type partial_ff, partial_in, part_sum;
   logic [SRC_W-1:0] scol_ff, scol_in, srow_ff, srow_in;
   logic [SRC_W-1:0] bcol_ff, bcol_in, brow_ff, brow_in;
   logic [DST_W-1:0] tcol_ff, tcol_in, trow_ff, trow_in;

   trio_type hold_ff, hold_in;
   logic [DST_W-1:0] col_ff, col_in;
   logic brow_nz_ff, brow_nz_in, emit_ff, emit_in;
   logic [ADDR_OUT_W-1:0] addr_ff, addr_in;
   logic fdone_ff, fdone_in;

   logic rv_ff, rv_in;
   logic [ADDR_OUT_W-1:0] raddr_ff, raddr_in;
   logic [15:0] rpix_ff, rpix_in;
   logic rfd_ff, rfd_in;

   logic accept, inbox, box_end, last_box_row, line_end, frame_end, out_free;
   logic [SRC_W:0] bcol_inc, brow_inc, scol_inc, srow_inc;
   logic [2*DST_W-1:0] prod;
   logic [DST_W-1:0] col_rev;
   trio_type acc, rd_data, quot, div_dnd, div_dsr;
   logic div_start, line_we, line_re;
   div_stat_type div_stat;
   logic [CHAN_W-1:0] r8, g8, b8;

   assign accept = req_valid && !req_stall;
   assign out_free = !rv_ff || !rsp_stall;

   // per-pixel counter, channel-sum and rotated-address logic
   always_comb begin
      inbox = (tcol_ff < tw_ff) && (trow_ff < th_ff);
      bcol_inc = {1'b0, bcol_ff} + 1'b1;
      brow_inc = {1'b0, brow_ff} + 1'b1;
      scol_inc = {1'b0, scol_ff} + 1'b1;
      srow_inc = {1'b0, srow_ff} + 1'b1;
      box_end = inbox && (bcol_inc >= {1'b0, wr_ff});
      last_box_row = brow_inc >= {1'b0, hr_ff};
      line_end = scol_inc >= {1'b0, sw_ff};
      frame_end = line_end && (srow_inc >= {1'b0, sh_ff});
      part_sum[0] = partial_ff[0] + SUM_W'(req_red_in);
      part_sum[1] = partial_ff[1] + SUM_W'(req_green_in);
      part_sum[2] = partial_ff[2] + SUM_W'(req_blue_in);
      col_rev = tw_ff - DST_W'(1) - tcol_ff;
      prod = {{DST_W{1'b0}}, th_ff} * {{DST_W{1'b0}}, col_rev};
   end

   always_comb begin
      state_in = state_ff;
      dirty_in = dirty_ff;
      wr_in = wr_ff;
      hr_in = hr_ff;
      area_in = area_ff;
      ok_in = ok_ff;
      partial_in = partial_ff;
      scol_in = scol_ff;
      srow_in = srow_ff;
      bcol_in = bcol_ff;
      brow_in = brow_ff;
      tcol_in = tcol_ff;
      trow_in = trow_ff;
      hold_in = hold_ff;
      col_in = col_ff;
      brow_nz_in = brow_nz_ff;
      emit_in = emit_ff;
      addr_in = addr_ff;
      fdone_in = fdone_ff;
      rv_in = rv_ff;
      raddr_in = raddr_ff;
      rpix_in = rpix_ff;
      rfd_in = rfd_ff;
      div_start = 1'b0;
      div_dnd = '0;
      div_dsr = '0;
      line_we = 1'b0;
      line_re = 1'b0;
      acc = '0;
      r8 = '0;
      g8 = '0;
      b8 = '0;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      if (csr_write_enable) begin
         dirty_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (dirty_ff) begin
               div_start = 1'b1;
               div_dnd[0] = SUM_W'(sw_ff);
               div_dnd[1] = SUM_W'(sh_ff);
               div_dsr[0] = SUM_W'(tw_ff);
               div_dsr[1] = SUM_W'(th_ff);
               div_dsr[2] = SUM_W'(1);
               dirty_in = csr_write_enable;
               state_in = ST_CFG;
            end else if (accept && ok_ff) begin
               if (inbox) begin
                  if (box_end) begin
                     partial_in = '0;
                     bcol_in = '0;
                     tcol_in = tcol_ff + 1'b1;
                     line_re = 1'b1;
                     hold_in = part_sum;
                     col_in = tcol_ff;
                     brow_nz_in = brow_ff != '0;
                     emit_in = last_box_row;
                     addr_in = ADDR_OUT_W'(prod + (2*DST_W)'(trow_ff));
                     fdone_in = (tcol_ff + 1'b1 == tw_ff) && (trow_ff + 1'b1 == th_ff);
                     state_in = ST_ACC;
                  end else begin
                     partial_in = part_sum;
                     bcol_in = bcol_inc[SRC_W-1:0];
                  end
               end
               scol_in = scol_inc[SRC_W-1:0];
               if (line_end) begin
                  scol_in = '0;
                  bcol_in = '0;
                  tcol_in = '0;
                  partial_in = '0;
                  if (trow_ff < th_ff) begin
                     if (last_box_row) begin
                        brow_in = '0;
                        trow_in = trow_ff + 1'b1;
                     end else begin
                        brow_in = brow_inc[SRC_W-1:0];
                     end
                  end
                  srow_in = srow_inc[SRC_W-1:0];
                  if (frame_end) begin
                     srow_in = '0;
                     brow_in = '0;
                     trow_in = '0;
                  end
               end
            end
         end
         ST_CFG: begin
            if (div_stat.done) begin
               wr_in = quot[0][SRC_W-1:0];
               hr_in = quot[1][SRC_W-1:0];
               state_in = ST_AREA;
            end
         end
         ST_AREA: begin
            area_in = wr_ff * hr_ff;
            ok_in = (sw_ff != '0) && (sh_ff != '0) && (tw_ff != '0) && (th_ff != '0)
               && (32'(sw_ff) <= MAX_SOURCE_DIM) && (32'(sh_ff) <= MAX_SOURCE_DIM)
               && (32'(tw_ff) <= MAX_TARGET_WIDTH) && (32'(th_ff) <= MAX_TARGET_HEIGHT)
               && (wr_ff != '0) && (hr_ff != '0);
            state_in = ST_IDLE;
         end
         ST_ACC: begin
            for (int i = 0; i < 3; i++) begin
               acc[i] = hold_ff[i] + (brow_nz_ff ? rd_data[i] : '0);
            end
            if (emit_ff) begin
               div_start = 1'b1;
               div_dnd = acc;
               for (int i = 0; i < 3; i++) begin
                  div_dsr[i] = SUM_W'(area_ff);
               end
               state_in = ST_DIV;
            end else begin
               line_we = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               r8 = (quot[0] > SUM_W'(255)) ? 8'hff : quot[0][CHAN_W-1:0];
               g8 = (quot[1] > SUM_W'(255)) ? 8'hff : quot[1][CHAN_W-1:0];
               b8 = (quot[2] > SUM_W'(255)) ? 8'hff : quot[2][CHAN_W-1:0];
               rv_in = 1'b1;
               raddr_in = addr_ff;
               rpix_in = {r8[7:3], g8[7:2], b8[7:3]};
               rfd_in = fdone_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      wr_ff <= wr_in;
      hr_ff <= hr_in;
      area_ff <= area_in;
      hold_ff <= hold_in;
      col_ff <= col_in;
      brow_nz_ff <= brow_nz_in;
      emit_ff <= emit_in;
      addr_ff <= addr_in;
      fdone_ff <= fdone_in;
      raddr_ff <= raddr_in;
      rpix_ff <= rpix_in;
      rfd_ff <= rfd_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         dirty_ff <= 1'b1;
         ok_ff <= 1'b0;
         sw_ff <= SRC_W'(640);
         sh_ff <= SRC_W'(480);
         tw_ff <= DST_W'(320);
         th_ff <= DST_W'(240);
         partial_ff <= '0;
         scol_ff <= '0;
         srow_ff <= '0;
         bcol_ff <= '0;
         brow_ff <= '0;
         tcol_ff <= '0;
         trow_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         ok_ff <= ok_in;
         partial_ff <= partial_in;
         scol_ff <= scol_in;
         srow_ff <= srow_in;
         bcol_ff <= bcol_in;
         brow_ff <= brow_in;
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
         rv_ff <= rv_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SOURCE_WIDTH: sw_ff <= csr_write_data;
               CSR_SOURCE_HEIGHT: sh_ff <= csr_write_data;
               CSR_TARGET_WIDTH: tw_ff <= csr_write_data[DST_W-1:0];
               CSR_TARGET_HEIGHT: th_ff <= csr_write_data[DST_W-1:0];
               default: ;
            endcase
         end
      end
   end

   bds_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dnd),
      .divisor(div_dsr),
      .quotient(quot),
      .stat(div_stat)
   );

   bds_line #(
      .DEPTH(MAX_TARGET_WIDTH),
      .AW(AW)
   ) u_line (
      .clock(clock),
      .wr_en(line_we),
      .wr_addr(AW'(col_ff)),
      .wr_data(acc),
      .rd_en(line_re),
      .rd_addr(AW'(tcol_ff)),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE) || dirty_ff;
   assign rsp_valid = rv_ff;
   assign rsp_pixel_address = raddr_ff;
   assign rsp_pixel_565 = rpix_ff;
   assign rsp_frame_done = rfd_ff;

   `BDS_ASSERT_NOW(a_we_in_acc, clock, reset, line_we, state_ff == ST_ACC, "line write outside accumulate")
   `BDS_ASSERT_NOW(a_rsp_from_put, clock, reset, $rose(rv_ff), $past(state_ff) == ST_PUT, "result without divide")
   `BDS_ASSERT_NEXT(a_read_then_acc, clock, reset, line_re, state_ff == ST_ACC, "line read not followed by accumulate")
   `BDS_ASSERT_NOW(a_div_busy, clock, reset, state_ff == ST_DIV && !div_stat.done, div_stat.busy, "divider idle during divide")
endmodule
`default_nettype wire

// File: hdl/bds_div.sv
// three-lane restoring divider, one quotient bit per cycle
// depends on bds_pkg
`default_nettype none
module bds_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire bds_pkg::trio_type dividend,
   input  wire bds_pkg::trio_type divisor,
   output bds_pkg::trio_type quotient,
   output bds_pkg::div_stat_type stat
);
   import bds_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   trio_type rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [SUM_W:0] shifted;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = '0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            shifted = {rem_ff[i], quo_ff[i][SUM_W-1]};
            if (shifted >= {1'b0, den_ff[i]}) begin
               rem_in[i] = SUM_W'(shifted - {1'b0, den_ff[i]});
               quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[i] = shifted[SUM_W-1:0];
               quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign stat = '{busy: busy_ff, done: done_ff};
endmodule
`default_nettype wire

// File: hdl/bds_line.sv
// line store of per-column channel sums, one write and one registered read
// depends on bds_pkg
`default_nettype none
module bds_line #(
   parameter int DEPTH = 512,
   parameter int AW = 9
) (
   input  wire logic clock,
   input  wire logic wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire bds_pkg::trio_type wr_data,
   input  wire logic rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output bds_pkg::trio_type rd_data
);
   import bds_pkg::*;

   trio_type mem [DEPTH];
   trio_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire
